### rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared sizes, slot tags, command and status codes for the hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // Number of slots; a power of two, so the start slot is the low hash bits.
  localparam int SLOTS      = 1024;
  localparam int IDX_BITS   = $clog2(SLOTS);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 64;
  localparam int HASH_BITS  = 32;
  localparam int LIMIT_BITS = 10;
  localparam int TAG_BITS   = 2;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 10'd768;

  localparam logic [TAG_BITS-1:0] TAG_EMPTY = 2'd0;
  localparam logic [TAG_BITS-1:0] TAG_LIVE  = 2'd1;
  localparam logic [TAG_BITS-1:0] TAG_TOMB  = 2'd2;

  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

endpackage

### rtl/lpht_ifs.sv
// ----------------------------------------------------------------------------
// lpht interfaces
// Request, response and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface lpht_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] key_id;
  logic [31:0] key_hash;
  logic [63:0] value_in;

  modport source (output valid, output cmd, output key_id, output key_hash,
                  output value_in, input ready);
  modport sink   (input valid, input cmd, input key_id, input key_hash,
                  input value_in, output ready);
endinterface

interface lpht_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        was_new_key;
  logic [63:0] value_out;

  modport source (output valid, output status, output was_new_key,
                  output value_out, input ready);
  modport sink   (input valid, input status, input was_new_key,
                  input value_out, output ready);
endinterface

interface lpht_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int ADDR_BITS = 10,
  parameter int WIDTH     = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_BITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/linear_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// After reset the block sweeps the slot-tag memory to empty, one slot a
// cycle; requests are held off meanwhile, while writes to the limit
// register are taken at any time. Each request then probes 1 to 1024 slots:
// the shared probe step reads one slot from the tag, key and value memories
// per cycle, and the update state then applies the update and loads the
// response register, waiting while an earlier response beat is not taken.
// The response register lets the next request be accepted while the
// previous response beat still waits.
module linear_probe_hash_table_top (
  input logic        clk,
  input logic        rst,
  lpht_req_if.sink   req,
  lpht_rsp_if.source rsp,
  lpht_cfg_if.sink   cfg
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_PROBE, ST_ACT} state_t;

  state_t state;

  logic [lpht_pkg::IDX_BITS-1:0]   clr_addr;
  logic [lpht_pkg::IDX_BITS-1:0]   idx;
  logic [lpht_pkg::IDX_BITS-1:0]   visits;
  logic                            tomb_seen;
  logic [lpht_pkg::IDX_BITS-1:0]   tomb_idx;
  logic                            hit;
  logic [lpht_pkg::IDX_BITS-1:0]   target;
  logic                            target_ok;
  logic                            target_tomb;
  logic [lpht_pkg::VALUE_BITS-1:0] hit_value;
  logic [1:0]                      cmd_q;
  logic [lpht_pkg::KEY_BITS-1:0]   key_q;
  logic [lpht_pkg::VALUE_BITS-1:0] val_q;
  logic [lpht_pkg::CNT_BITS-1:0]   used_count;
  logic [lpht_pkg::LIMIT_BITS-1:0] max_used;

  logic                            out_valid;
  logic [1:0]                      out_status;
  logic                            out_new;
  logic [lpht_pkg::VALUE_BITS-1:0] out_value;

  // Memory ports.
  logic [lpht_pkg::IDX_BITS-1:0]   rd_addr;
  logic [lpht_pkg::TAG_BITS-1:0]   tag_rd;
  logic [lpht_pkg::KEY_BITS-1:0]   key_rd;
  logic [lpht_pkg::VALUE_BITS-1:0] val_rd;
  logic                            tag_we;
  logic                            key_we;
  logic                            val_we;
  logic [lpht_pkg::IDX_BITS-1:0]   wr_addr;
  logic [lpht_pkg::TAG_BITS-1:0]   tag_wdata;

  // Probe step decisions.
  logic                            is_tomb;
  logic                            is_empty;
  logic                            match;
  logic                            last;
  logic                            tomb_ok;
  logic [lpht_pkg::IDX_BITS-1:0]   first_tomb;
  logic [lpht_pkg::IDX_BITS-1:0]   idx_inc;

  // Update cycle.
  logic                            act_go;
  logic [1:0]                      act_status;
  logic                            act_new;
  logic [lpht_pkg::VALUE_BITS-1:0] act_value;
  logic                            used_inc;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.was_new_key = out_new;
  assign rsp.value_out   = out_value;

  assign idx_inc = lpht_pkg::IDX_BITS'(idx + 1'b1);

  // While probing, the next slot is read speculatively so that a slot is
  // examined every cycle.
  assign rd_addr = (state == ST_IDLE) ? req.key_hash[lpht_pkg::IDX_BITS-1:0] : idx_inc;

  assign is_tomb    = (tag_rd == lpht_pkg::TAG_TOMB);
  assign is_empty   = (tag_rd != lpht_pkg::TAG_LIVE) && !is_tomb;
  assign match      = (tag_rd == lpht_pkg::TAG_LIVE) && (key_rd == key_q);
  assign last       = (visits == {lpht_pkg::IDX_BITS{1'b1}});
  assign tomb_ok    = tomb_seen || is_tomb;
  assign first_tomb = tomb_seen ? tomb_idx : idx;

  assign act_go = (state == ST_ACT) && (!out_valid || rsp.ready);

  always_comb begin
    act_status = lpht_pkg::STATUS_DONE;
    act_new    = 1'b0;
    act_value  = '0;
    used_inc   = 1'b0;
    tag_we     = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    wr_addr    = target;
    tag_wdata  = lpht_pkg::TAG_LIVE;
    if (state == ST_CLEAR) begin
      tag_we    = 1'b1;
      wr_addr   = clr_addr;
      tag_wdata = lpht_pkg::TAG_EMPTY;
    end else if (act_go) begin
      case (cmd_q)
        lpht_pkg::CMD_SET: begin
          if (hit) begin
            val_we = 1'b1;
          end else if (!target_ok) begin
            act_status = lpht_pkg::STATUS_FULL;
          end else if (target_tomb) begin
            tag_we  = 1'b1;
            key_we  = 1'b1;
            val_we  = 1'b1;
            act_new = 1'b1;
          end else if (used_count >= {1'b0, max_used}) begin
            act_status = lpht_pkg::STATUS_FULL;
          end else begin
            tag_we   = 1'b1;
            key_we   = 1'b1;
            val_we   = 1'b1;
            act_new  = 1'b1;
            used_inc = 1'b1;
          end
        end
        lpht_pkg::CMD_GET: begin
          if (hit) begin
            act_value = hit_value;
          end else begin
            act_status = lpht_pkg::STATUS_NOTFOUND;
          end
        end
        lpht_pkg::CMD_DEL: begin
          if (hit) begin
            tag_we    = 1'b1;
            tag_wdata = lpht_pkg::TAG_TOMB;
          end else begin
            act_status = lpht_pkg::STATUS_NOTFOUND;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      used_count <= '0;
      max_used   <= lpht_pkg::LIMIT_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        max_used <= cfg.data;
      end
      if (act_go) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (used_inc) begin
        used_count <= used_count + 1'b1;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= lpht_pkg::IDX_BITS'(clr_addr + 1'b1);
          if (clr_addr == {lpht_pkg::IDX_BITS{1'b1}}) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (match || is_empty || last) begin
            state <= ST_ACT;
          end
        end
        ST_ACT: begin
          if (act_go) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end

    // Datapath registers carry no reset.
    case (state)
      ST_IDLE: begin
        cmd_q     <= req.cmd;
        key_q     <= req.key_id;
        val_q     <= req.value_in;
        idx       <= req.key_hash[lpht_pkg::IDX_BITS-1:0];
        visits    <= '0;
        tomb_seen <= 1'b0;
        hit       <= 1'b0;
      end
      ST_PROBE: begin
        if (match) begin
          hit       <= 1'b1;
          target    <= idx;
          target_ok <= 1'b1;
          hit_value <= val_rd;
        end else if (is_empty) begin
          target      <= first_tomb;
          target_ok   <= 1'b1;
          target_tomb <= tomb_seen;
        end else if (last) begin
          // Whole table visited with no empty slot.
          target      <= first_tomb;
          target_ok   <= tomb_ok;
          target_tomb <= 1'b1;
        end else begin
          if (is_tomb && !tomb_seen) begin
            tomb_seen <= 1'b1;
            tomb_idx  <= idx;
          end
          idx    <= idx_inc;
          visits <= lpht_pkg::IDX_BITS'(visits + 1'b1);
        end
      end
      default: begin
      end
    endcase

    if (act_go) begin
      out_status <= act_status;
      out_new    <= act_new;
      out_value  <= act_value;
    end
  end

  lpht_ram #(.ADDR_BITS(lpht_pkg::IDX_BITS), .WIDTH(lpht_pkg::TAG_BITS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (wr_addr),
    .wdata (tag_wdata),
    .raddr (rd_addr),
    .rdata (tag_rd)
  );

  lpht_ram #(.ADDR_BITS(lpht_pkg::IDX_BITS), .WIDTH(lpht_pkg::KEY_BITS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  lpht_ram #(.ADDR_BITS(lpht_pkg::IDX_BITS), .WIDTH(lpht_pkg::VALUE_BITS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (wr_addr),
    .wdata (val_q),
    .raddr (rd_addr),
    .rdata (val_rd)
  );

`ifndef SYNTH
  a_accept_starts_probe: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state == ST_PROBE)
    else $error("accepted request did not start a probe");

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used_count <= lpht_pkg::CNT_BITS'(lpht_pkg::SLOTS))
    else $error("used slot count exceeds the table size");

  a_used_steps: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && used_count != $past(used_count)
      |-> used_count == lpht_pkg::CNT_BITS'($past(used_count) + 1'b1))
    else $error("used slot count changed by other than one");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status != lpht_pkg::STATUS_DONE |-> !out_new && out_value == '0)
    else $error("failed response carries a new-key flag or a value");
`endif

endmodule

### tb/lpht_table_checker.sv
// ----------------------------------------------------------------------------
// lpht_table_checker
// Watches the request, response and limit channels of the hash table, keeps
// its own copy of the slot store and predicts every response beat, then
// compares each response field with the oldest prediction still owed.
// ----------------------------------------------------------------------------
module lpht_table_checker
  import lpht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  lpht_req_if  req,
  lpht_rsp_if  rsp,
  lpht_cfg_if  cfg,
  output int   mismatches,
  output int   replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]            status;
    logic                  was_new_key;
    logic [VALUE_BITS-1:0] value_out;
  } reply_t;

  logic [TAG_BITS-1:0]   tag_mem [SLOTS];
  logic [KEY_BITS-1:0]   key_mem [SLOTS];
  logic [VALUE_BITS-1:0] val_mem [SLOTS];
  logic [CNT_BITS-1:0]   used_slots;
  logic [LIMIT_BITS-1:0] slot_limit;
  reply_t                owed_replies [$];
  int                    errors = 0;

  assign mismatches = errors;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  // Walks forward from the start slot. Returns the live match, else the first
  // tombstone passed, else the empty slot that stopped the walk.
  function automatic logic [IDX_BITS-1:0] find_slot(input logic [KEY_BITS-1:0] key,
                                                    input logic [HASH_BITS-1:0] hash,
                                                    output bit hit, output bit have_slot);
    logic [IDX_BITS-1:0] idx;
    logic [IDX_BITS-1:0] tomb_idx;
    bit                  tomb_seen;
    idx       = hash[IDX_BITS-1:0];
    tomb_idx  = '0;
    tomb_seen = 1'b0;
    hit       = 1'b0;
    have_slot = 1'b0;
    for (int n = 0; n < SLOTS; n++) begin
      if (tag_mem[idx] == TAG_LIVE) begin
        if (key_mem[idx] == key) begin
          hit       = 1'b1;
          have_slot = 1'b1;
          return idx;
        end
      end else if (tag_mem[idx] == TAG_TOMB) begin
        if (!tomb_seen) begin
          tomb_seen = 1'b1;
          tomb_idx  = idx;
        end
      end else begin
        have_slot = 1'b1;
        return tomb_seen ? tomb_idx : idx;
      end
      idx = idx + 1'b1;
    end
    have_slot = tomb_seen;
    return tomb_idx;
  endfunction

  function automatic reply_t predict_table_op(input logic [1:0] op,
                                              input logic [KEY_BITS-1:0] key,
                                              input logic [HASH_BITS-1:0] hash,
                                              input logic [VALUE_BITS-1:0] val);
    reply_t              r;
    logic [IDX_BITS-1:0] s;
    bit                  hit;
    bit                  have_slot;
    r = '0;
    s = find_slot(key, hash, hit, have_slot);
    case (op)
      CMD_SET: begin
        if (hit) begin
          val_mem[s] = val;
        end else if (!have_slot) begin
          r.status = STATUS_FULL;
        end else if (tag_mem[s] == TAG_TOMB) begin
          // Reusing a tombstone leaves the occupancy count alone.
          tag_mem[s]    = TAG_LIVE;
          key_mem[s]    = key;
          val_mem[s]    = val;
          r.was_new_key = 1'b1;
        end else if (used_slots >= {1'b0, slot_limit}) begin
          r.status = STATUS_FULL;
        end else begin
          tag_mem[s]    = TAG_LIVE;
          key_mem[s]    = key;
          val_mem[s]    = val;
          used_slots    = used_slots + 1'b1;
          r.was_new_key = 1'b1;
        end
      end
      CMD_GET: begin
        if (hit) r.value_out = val_mem[s];
        else r.status = STATUS_NOTFOUND;
      end
      CMD_DEL: begin
        if (hit) tag_mem[s] = TAG_TOMB;
        else r.status = STATUS_NOTFOUND;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) tag_mem[i] = TAG_EMPTY;
      used_slots = '0;
      slot_limit = LIMIT_RESET;
      owed_replies.delete();
    end else begin
      if (cfg.valid && cfg.ready) slot_limit = cfg.data;
      if (rsp.valid && rsp.ready) begin
        if (owed_replies.size() == 0) begin
          report_mismatch("response beat with no request outstanding", '0, '0);
        end else begin
          want = owed_replies.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.was_new_key !== want.was_new_key)
            report_mismatch("was_new_key", 64'(rsp.was_new_key), 64'(want.was_new_key));
          if (rsp.value_out !== want.value_out)
            report_mismatch("value_out", rsp.value_out, want.value_out);
        end
      end
      if (req.valid && req.ready)
        owed_replies.push_back(predict_table_op(req.cmd, req.key_id, req.key_hash,
                                                req.value_in));
    end
    replies_owed <= owed_replies.size();
  end

endmodule

### tb/linear_probe_hash_table_top_tb.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_tb
// Drives set, get and delete requests into the hash table under a range of
// occupancy limits, with random gaps on the request side and random stalls on
// the response side, and leaves the checking to the table checker.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lpht_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         POOL_KEYS  = 256;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   replies_owed;
  int   burst_left = 0;

  logic [KEY_BITS-1:0]  pool_key  [POOL_KEYS];
  logic [HASH_BITS-1:0] pool_hash [POOL_KEYS];

  lpht_req_if req_ch ();
  lpht_rsp_if rsp_ch ();
  lpht_cfg_if cfg_ch ();

  linear_probe_hash_table_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  lpht_table_checker table_checker (
    .clk          (clk),
    .rst          (rst),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .cfg          (cfg_ch),
    .mismatches   (fail_count),
    .replies_owed (replies_owed)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one, and occasional bursts of
  // back-to-back beats.
  function automatic int pick_gap();
    int w;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    w = $urandom_range(0, 99);
    if (w < 2) begin
      burst_left = 40;
      return 0;
    end
    if (w < 55) return 0;
    if (w < 85) return $urandom_range(1, 3);
    if (w < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  task automatic issue_op(input logic [1:0] op, input logic [KEY_BITS-1:0] key,
                          input logic [HASH_BITS-1:0] hash,
                          input logic [VALUE_BITS-1:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.cmd      <= op;
    req_ch.key_id   <= key;
    req_ch.key_hash <= hash;
    req_ch.value_in <= val;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // The owed count is registered behind the handshake, so let it update before looking.
  task automatic drain_replies();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] limit);
    drain_replies();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= limit;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // A quarter of the keys crowd the top of the table so that probes wrap,
  // and another quarter share a narrow band to build long collision runs.
  task automatic build_key_pool();
    int w;
    for (int i = 0; i < POOL_KEYS; i++) begin
      pool_key[i]  = $urandom;
      pool_hash[i] = $urandom;
      w = $urandom_range(0, 99);
      if (w < 25)
        pool_hash[i][IDX_BITS-1:0] = IDX_BITS'(SLOTS - 8 + $urandom_range(0, 7));
      else if (w < 50)
        pool_hash[i][IDX_BITS-1:0] = IDX_BITS'(100 + $urandom_range(0, 15));
    end
  endtask

  task automatic random_op(input int base, input int count);
    logic [1:0]            op;
    logic [KEY_BITS-1:0]   key;
    logic [HASH_BITS-1:0]  hash;
    logic [VALUE_BITS-1:0] val;
    int                    pick;
    int                    w;
    pick = base + $urandom_range(0, count - 1);
    key  = pool_key[pick];
    hash = pool_hash[pick];
    w = $urandom_range(0, 99);
    if (w < 10) begin
      key  = $urandom;
      hash = $urandom;
    end else if (w < 13) begin
      hash = $urandom;
    end
    w = $urandom_range(0, 99);
    if (w < 45) op = CMD_SET;
    else if (w < 75) op = CMD_GET;
    else if (w < 95) op = CMD_DEL;
    else op = CMD_UNUSED;
    val = {$urandom, $urandom};
    w = $urandom_range(0, 99);
    if (w < 3) val = '1;
    else if (w < 6) val = '0;
    issue_op(op, key, hash, val);
    if ($urandom_range(0, 99) == 0) drain_replies();
  endtask

  task automatic run_phase(input logic [LIMIT_BITS-1:0] limit, input int base,
                           input int count, input int ops);
    write_limit(limit);
    repeat (ops) random_op(base, count);
  endtask

  initial begin
    int  len;
    int  w;
    bit  hold;
    forever begin
      w = $urandom_range(0, 99);
      if (w < 8) begin
        hold = 1'b1;
        len  = $urandom_range(100, 300);
      end else if (w < 55) begin
        hold = 1'b1;
        len  = $urandom_range(1, 8);
      end else begin
        hold = 1'b0;
        w = $urandom_range(0, 99);
        if (w < 80) len = $urandom_range(1, 3);
        else if (w < 95) len = $urandom_range(4, 12);
        else len = $urandom_range(30, 80);
      end
      rsp_ch.ready <= hold;
      repeat (len) @(posedge clk);
    end
  end

  initial begin
    rst             <= 1'b1;
    req_ch.valid    <= 1'b0;
    req_ch.cmd      <= CMD_SET;
    req_ch.key_id   <= '0;
    req_ch.key_hash <= '0;
    req_ch.value_in <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.data     <= '0;
    build_key_pool();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // With a zero limit nothing can be inserted into an empty table.
    write_limit(10'd0);
    issue_op(CMD_SET, 32'h0000_0000, 32'h0000_0000, 64'h0123_4567_89ab_cdef);
    issue_op(CMD_GET, 32'h0000_0000, 32'h0000_0000, '0);
    issue_op(CMD_DEL, 32'h0000_0000, 32'h0000_0000, '0);
    issue_op(CMD_UNUSED, '1, '1, '1);

    // Collisions at the last slot wrap round to the first.
    write_limit(10'd4);
    issue_op(CMD_SET, 32'hffff_ffff, 32'hffff_ffff, '1);
    issue_op(CMD_SET, 32'h0000_0000, 32'h0000_03ff, '0);
    issue_op(CMD_SET, 32'h0000_0001, 32'hffff_fc00, 64'h0123_4567_89ab_cdef);
    issue_op(CMD_GET, 32'hffff_ffff, 32'hffff_ffff, '0);
    issue_op(CMD_GET, 32'h0000_0000, 32'h0000_03ff, '0);
    issue_op(CMD_SET, 32'hffff_ffff, 32'hffff_ffff, 64'h5555_5555_5555_5555);
    issue_op(CMD_DEL, 32'h0000_0000, 32'h0000_03ff, '0);
    issue_op(CMD_GET, 32'h0000_0001, 32'hffff_fc00, '0);
    issue_op(CMD_GET, 32'h0000_0000, 32'h0000_03ff, '0);
    issue_op(CMD_DEL, 32'h0000_0000, 32'h0000_03ff, '0);
    issue_op(CMD_SET, 32'h8000_0000, 32'h0000_03ff, 64'haaaa_aaaa_aaaa_aaaa);
    issue_op(CMD_SET, 32'haaaa_aaaa, 32'h1234_5555, 64'hfedc_ba98_7654_3210);
    issue_op(CMD_SET, 32'h5555_5555, 32'haaaa_aaaa, 64'h1111_2222_3333_4444);
    issue_op(CMD_DEL, 32'h8000_0000, 32'h0000_03ff, '0);
    // At the limit, a tombstone can still be taken over by a new key.
    issue_op(CMD_SET, 32'h5555_5555, 32'h0000_03ff, 64'h1111_2222_3333_4444);
    issue_op(CMD_GET, 32'h5555_5555, 32'h0000_03ff, '0);
    issue_op(CMD_UNUSED, '0, '0, '0);
    issue_op(CMD_GET, 32'haaaa_aaaa, 32'h1234_5555, '0);

    run_phase(10'd1023, 0, 48, 300);
    run_phase(10'd24, 0, 48, 200);
    run_phase(10'd0, 0, 48, 150);
    run_phase(10'd120, 48, 64, 350);
    run_phase(10'd1023, 112, 144, 550);

    drain_replies();
    repeat (1100) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #(64'd20_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/lpht_pkg.sv
rtl/lpht_ifs.sv
rtl/lpht_ram.sv
rtl/linear_probe_hash_table_top.sv
tb/lpht_table_checker.sv
tb/linear_probe_hash_table_top_tb.sv
